/* src/u2da_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the unsigned-to-decimal ASCII converter.
// Used by u2da_cell and unsigned_to_decimal_ascii; depends on nothing else.
package u2da_pkg;

   localparam int MAX_DIGITS_DEF  = 10;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int DIGIT_W         = 4;
   localparam int ASCII_W         = 6;

   localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'd48;

   // per-cycle operation of every digit cell in the chain
   typedef enum logic [1:0] {
      CELL_HOLD  = 2'd0,
      CELL_CLEAR = 2'd1,
      CELL_CONV  = 2'd2,
      CELL_SHIFT = 2'd3
   } cell_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

/* src/u2da_cell.sv */
`timescale 1ns / 1ps
// One BCD digit cell: shift-and-add-3 step during conversion, digit shift
// toward the output during emission. Depends on u2da_pkg.
module u2da_cell
   import u2da_pkg::*;
(
   input  logic                clock,
   input  cell_mode_type       mode,
   input  logic                bit_in,
   input  logic [DIGIT_W-1:0]  lower_digit,
   output logic                carry_out,
   output logic [DIGIT_W-1:0]  digit_out
);

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] adj;

   // digits stay 0..9, so the corrected value fits in four bits
   assign adj       = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign carry_out = adj[DIGIT_W-1];
   assign digit_out = digit_ff;

   always_comb begin
      unique case (mode)
         CELL_HOLD:  digit_in = digit_ff;
         CELL_CLEAR: digit_in = '0;
         CELL_CONV:  digit_in = {adj[DIGIT_W-2:0], bit_in};
         CELL_SHIFT: digit_in = lower_digit;
         default:    digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

/* src/unsigned_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// Unsigned binary to decimal ASCII text, most significant digit first.
// Sequence: a load step, then one conversion step per value bit through the digit-cell chain,
// then an emit step for each of the MAX_DIGITS digit positions (a leading zero spends its step
// with no strobe); each character is strobed in the cycle after its emit step. A new number
// is taken only while idle, once the last emit step is done, for any value; the receiver cannot
// stall. Reset (synchronous, active high) returns to idle, no strobe.
module unsigned_to_decimal_ascii
   import u2da_pkg::*;
#(
   parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VALUE_WIDTH-1:0] req_number,
   output logic                   rsp_valid,
   output logic [ASCII_W-1:0]     rsp_ascii_digit,
   output logic                   rsp_last_digit
);

   localparam int BW = $clog2(VALUE_WIDTH);
   localparam int CW = $clog2(MAX_DIGITS + 1);

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [BW-1:0]          bit_cnt_ff, bit_cnt_in;
   logic [CW-1:0]          dig_cnt_ff, dig_cnt_in;
   logic                   ovf_ff, ovf_in;
   logic                   started_ff, started_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ASCII_W-1:0]     rsp_ascii_ff, rsp_ascii_in;
   logic                   rsp_last_ff, rsp_last_in;

   cell_mode_type          mode;
   logic [MAX_DIGITS:0]    carry;
   logic [DIGIT_W-1:0]     digit [MAX_DIGITS+1];
   logic [DIGIT_W-1:0]     top_digit;
   logic                   ovf_nxt;

   // cell 0 takes the value MSB; zeros shift into it during emission
   assign carry[0]   = value_ff[VALUE_WIDTH-1];
   assign digit[0]   = '0;
   assign top_digit  = digit[MAX_DIGITS];
   assign ovf_nxt    = ovf_ff | carry[MAX_DIGITS];

   genvar gi;
   generate
      for (gi = 0; gi < MAX_DIGITS; gi++) begin : g_cell
         u2da_cell u_cell (
            .clock       (clock),
            .mode        (mode),
            .bit_in      (carry[gi]),
            .lower_digit (digit[gi]),
            .carry_out   (carry[gi+1]),
            .digit_out   (digit[gi+1])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      ovf_in       = ovf_ff;
      started_in   = started_ff;
      rsp_valid_in = 1'b0;
      rsp_ascii_in = rsp_ascii_ff;
      rsp_last_in  = rsp_last_ff;
      mode         = CELL_HOLD;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode       = CELL_CLEAR;
               value_in   = req_number;
               bit_cnt_in = BW'(VALUE_WIDTH - 1);
               ovf_in     = 1'b0;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            mode     = CELL_CONV;
            value_in = {value_ff[VALUE_WIDTH-2:0], 1'b0};
            ovf_in   = ovf_nxt;
            if (bit_cnt_ff == '0) begin
               dig_cnt_in = CW'(MAX_DIGITS);
               // a carry out of the top cell means the text fills every digit
               started_in = ovf_nxt;
               state_in   = ST_EMIT;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            mode       = CELL_SHIFT;
            dig_cnt_in = dig_cnt_ff - 1'b1;
            if (started_ff || top_digit != '0 || dig_cnt_ff == CW'(1)) begin
               started_in   = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_ascii_in = ASCII_ZERO + ASCII_W'(top_digit);
               rsp_last_in  = (dig_cnt_ff == CW'(1));
               if (dig_cnt_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff    <= value_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      ovf_ff      <= ovf_in;
      started_ff  <= started_in;
      rsp_ascii_ff <= rsp_ascii_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ascii_digit = rsp_ascii_ff;
   assign rsp_last_digit  = rsp_last_ff;

endmodule
